// ===== rtl/bfa_pkg.sv =====
// Shared types, constants and helpers for the bitmap frame allocator.
package bfa_pkg;

  localparam int NUM_FRAMES_DEF = 65536;
  localparam int WORD_BITS_DEF  = 32;   // power of two
  localparam int LIMIT_W        = 17;
  localparam int FRAME_W        = 16;
  localparam int COUNT_W        = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'd65536;
  localparam int SCAN_IDX_W     = 6;
  localparam int SCAN_RUN_W     = 24;

  typedef enum logic [1:0] {
    FN_ALLOC_ONE = 2'd0,
    FN_ALLOC_RUN = 2'd1,
    FN_FREE      = 2'd2,
    FN_RESERVE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOMEM  = 2'd1,
    STAT_BADARG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RC_RD,
    S_RC_ACC,
    S_DONE
  } bfa_state_t;

  typedef struct packed {
    logic                  found;
    logic [SCAN_IDX_W-1:0] hit_bit;
    logic                  any_free;
    logic [SCAN_IDX_W-1:0] free_bit;
    logic [SCAN_RUN_W-1:0] run;
  } scan_res_t;

  function automatic logic [6:0] popcnt64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/bfa_bitmap_ram.sv =====
// Bitmap word memory: one write port, one registered read port.
module bfa_bitmap_ram import bfa_pkg::*; #(
  parameter int DEPTH = NUM_FRAMES_DEF / WORD_BITS_DEF,
  parameter int WIDTH = WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/bfa_word_scan.sv =====
// Per-word run finder: free-run lengths ending at each bit, first fit and first free bit.
module bfa_word_scan import bfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int XW        = 18
) (
  input  logic [WORD_BITS-1:0] used_bits,
  input  logic [XW-1:0]        run_in,
  input  logic [XW-1:0]        need,
  output scan_res_t            res
);

  localparam int BW = $clog2(WORD_BITS);

  logic [XW-1:0] run_j [WORD_BITS];

  always_comb begin
    logic          have;
    logic [BW-1:0] pos;
    for (int j = 0; j < WORD_BITS; j++) begin
      have = 1'b0;
      pos  = '0;
      for (int i = 0; i <= j; i++) begin
        if (used_bits[i]) begin
          have = 1'b1;
          pos  = BW'(i);
        end
      end
      run_j[j] = have ? (XW'(j) - XW'(pos)) : (run_in + XW'(j) + XW'(1));
    end
  end

  always_comb begin
    res = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!used_bits[j] && run_j[j] >= need) begin
        res.found   = 1'b1;
        res.hit_bit = SCAN_IDX_W'(j);
      end
      if (!used_bits[j]) begin
        res.any_free = 1'b1;
        res.free_bit = SCAN_IDX_W'(j);
      end
    end
    res.run = SCAN_RUN_W'(run_j[WORD_BITS-1]);
  end

endmodule

// ===== rtl/bitmap_frame_allocator_core.sv =====
// Bitmap page frame allocator: word-serial bitmap scan and read-modify-write over one RAM.
//
// One request at a time; busy is high while a request is in work, during the clearing
// pass after reset, which zeroes every bitmap word, and during the recount that follows
// a limit write, which reads every bitmap word below the limit. An allocation scans from
// the hint word and then reads and writes back each word it marks; free and reserve read
// and write back each word touched. The scan reads one bitmap word per cycle; the marking
// pass reads each word from the RAM's registered read port and then writes it back.
// The result appears on out_* for exactly one cycle with out_valid; it cannot be held off.
module bitmap_frame_allocator_core import bfa_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [FRAME_W-1:0]   in_frame_index,
  input  logic [COUNT_W-1:0]   in_count,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [FRAME_W-1:0]   out_result_frame,
  output logic [COUNT_W-1:0]   out_free_count,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_wdata
);

  localparam int NW = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int FW = $clog2(NUM_FRAMES + 1);
  localparam int M1 = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int M2 = ((AW + BW) > M1) ? (AW + BW) : M1;
  localparam int XW = M2 + 1;

  bfa_state_t state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               dirty_r, dirty_nxt;
  logic [XW-1:0]      used_r, used_nxt, hint_r, hint_nxt;
  logic [XW-1:0]      mw_r, mw_nxt, ms_r, ms_nxt, ew_r, ew_nxt;
  logic [BW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, hb_r, hb_nxt;
  logic               set_r, set_nxt;
  logic [XW-1:0]      scan_word_r, scan_word_nxt, sw_r, sw_nxt, proc_word_r, proc_word_nxt;
  logic               proc_valid_r, proc_valid_nxt, seen_r, seen_nxt;
  logic [XW-1:0]      run_r, run_nxt, ffr_r, ffr_nxt, need_r, need_nxt;
  status_t            status_r, status_nxt;
  logic [FRAME_W-1:0] result_r, result_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [FRAME_W-1:0] out_result_frame_r;
  logic [COUNT_W-1:0] out_free_count_r;

  logic [XW-1:0]      lim, nwl, last_word, limit_ext, need_in, run_end, first_ext, hit_f;
  logic [BW-1:0]      lim_lo;
  logic               accept, alloc_req;
  logic [WORD_BITS-1:0] rdata, scan_mask, mark_mask, rc_mask, new_word, changed;
  logic [6:0]         pc_changed, pc_used;
  scan_res_t          sres;
  logic               scan_hit, scan_end;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;

  assign limit_ext = XW'(limit_r);
  assign lim       = (limit_ext > XW'(NUM_FRAMES)) ? XW'(NUM_FRAMES) : limit_ext;
  assign nwl       = (lim + XW'(WORD_BITS - 1)) >> BW;
  assign last_word = nwl - XW'(1);
  assign lim_lo    = lim[BW-1:0];
  assign busy      = (state_r != S_IDLE) || dirty_r;
  assign accept    = start && !busy;
  assign alloc_req = (in_func == FN_ALLOC_ONE) || (in_func == FN_ALLOC_RUN);
  assign need_in   = (in_func == FN_ALLOC_ONE) ? XW'(1) : XW'(in_count);
  assign first_ext = XW'(in_frame_index);
  assign run_end   = first_ext + XW'(in_count) - XW'(1);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      scan_mask[j] = !((proc_word_r == sw_r) && (BW'(j) < hb_r)) &&
                     !((proc_word_r == last_word) && (lim_lo != '0) && (BW'(j) >= lim_lo));
      mark_mask[j] = ((mw_r != ms_r) || (BW'(j) >= lo_r)) &&
                     ((mw_r != ew_r) || (BW'(j) <= hi_r));
      rc_mask[j]   = (mw_r != last_word) || (lim_lo == '0) || (BW'(j) < lim_lo);
    end
  end

  bfa_word_scan #(.WORD_BITS(WORD_BITS), .XW(XW)) u_scan (
    .used_bits (rdata | ~scan_mask),
    .run_in    (run_r),
    .need      (need_r),
    .res       (sres)
  );

  assign scan_hit   = proc_valid_r && sres.found;
  assign scan_end   = proc_valid_r && !sres.found && (proc_word_r == last_word);
  assign hit_f      = (proc_word_r << BW) | XW'(sres.hit_bit[BW-1:0]);
  assign new_word   = set_r ? (rdata | mark_mask) : (rdata & ~mark_mask);
  assign changed    = set_r ? (mark_mask & ~rdata) : (mark_mask & rdata);
  assign pc_changed = popcnt64(64'(changed));
  assign pc_used    = popcnt64(64'(rdata & rc_mask));

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_MARK_WR);
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : new_word;
  assign ram_raddr = (state_r == S_SCAN) ? scan_word_r[AW-1:0] : mw_r[AW-1:0];

  bfa_bitmap_ram #(.DEPTH(NW), .WIDTH(WORD_BITS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (mw_r[AW-1:0]),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (mw_r == XW'(NW - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (dirty_r) begin
          if (nwl != '0) state_nxt = S_RC_RD;
        end else if (start) begin
          if (alloc_req) begin
            if (need_in == '0 || need_in > lim || hint_r >= lim) state_nxt = S_DONE;
            else state_nxt = S_SCAN;
          end else begin
            if (in_count == '0 || (first_ext + XW'(in_count)) > lim) state_nxt = S_DONE;
            else state_nxt = S_MARK_RD;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) state_nxt = S_MARK_RD;
        else if (scan_end) state_nxt = S_DONE;
      end
      S_MARK_RD: state_nxt = S_MARK_WR;
      S_MARK_WR: begin
        state_nxt = (mw_r == ew_r) ? S_DONE : S_MARK_RD;
      end
      S_RC_RD:  state_nxt = S_RC_ACC;
      S_RC_ACC: begin
        state_nxt = (mw_r == last_word) ? S_IDLE : S_RC_RD;
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    limit_nxt      = cfg_we ? cfg_wdata : limit_r;
    dirty_nxt      = dirty_r;
    used_nxt       = used_r;
    hint_nxt       = hint_r;
    mw_nxt         = mw_r;
    ms_nxt         = ms_r;
    ew_nxt         = ew_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    hb_nxt         = hb_r;
    set_nxt        = set_r;
    scan_word_nxt  = scan_word_r;
    sw_nxt         = sw_r;
    proc_word_nxt  = proc_word_r;
    proc_valid_nxt = proc_valid_r;
    seen_nxt       = seen_r;
    run_nxt        = run_r;
    ffr_nxt        = ffr_r;
    need_nxt       = need_r;
    status_nxt     = status_r;
    result_nxt     = result_r;
    unique case (state_r)
      S_CLEAR: begin
        mw_nxt = mw_r + XW'(1);
      end
      S_IDLE: begin
        if (dirty_r) begin
          dirty_nxt = 1'b0;
          used_nxt  = '0;
          mw_nxt    = '0;
        end else if (start) begin
          status_nxt = STAT_OK;
          result_nxt = '0;
          if (alloc_req) begin
            need_nxt       = need_in;
            sw_nxt         = hint_r >> BW;
            scan_word_nxt  = hint_r >> BW;
            hb_nxt         = hint_r[BW-1:0];
            proc_valid_nxt = 1'b0;
            seen_nxt       = 1'b0;
            run_nxt        = '0;
            if (need_in == '0) status_nxt = STAT_BADARG;
            else if (need_in > lim || hint_r >= lim) status_nxt = STAT_NOMEM;
          end else begin
            ms_nxt  = first_ext >> BW;
            mw_nxt  = first_ext >> BW;
            lo_nxt  = first_ext[BW-1:0];
            ew_nxt  = run_end >> BW;
            hi_nxt  = run_end[BW-1:0];
            set_nxt = (in_func == FN_RESERVE);
            if (in_count == '0 || (first_ext + XW'(in_count)) > lim) begin
              status_nxt = STAT_BADARG;
            end else if (in_func == FN_FREE && first_ext < hint_r) begin
              hint_nxt = first_ext;
            end
          end
        end
      end
      S_SCAN: begin
        scan_word_nxt  = scan_word_r + XW'(1);
        proc_word_nxt  = scan_word_r;
        proc_valid_nxt = 1'b1;
        if (scan_hit) begin
          hint_nxt   = seen_r ? ffr_r : ((proc_word_r << BW) | XW'(sres.free_bit[BW-1:0]));
          result_nxt = FRAME_W'(hit_f + XW'(1) - need_r);
          ms_nxt     = (hit_f + XW'(1) - need_r) >> BW;
          mw_nxt     = (hit_f + XW'(1) - need_r) >> BW;
          lo_nxt     = BW'(hit_f + XW'(1) - need_r);
          ew_nxt     = proc_word_r;
          hi_nxt     = sres.hit_bit[BW-1:0];
          set_nxt    = 1'b1;
        end else if (proc_valid_r) begin
          run_nxt = sres.run[XW-1:0];
          if (!seen_r && sres.any_free) begin
            seen_nxt = 1'b1;
            ffr_nxt  = (proc_word_r << BW) | XW'(sres.free_bit[BW-1:0]);
          end
          if (scan_end) status_nxt = STAT_NOMEM;
        end
      end
      S_MARK_RD: begin
      end
      S_MARK_WR: begin
        used_nxt = set_r ? (used_r + XW'(pc_changed)) : (used_r - XW'(pc_changed));
        mw_nxt   = mw_r + XW'(1);
      end
      S_RC_RD: begin
      end
      S_RC_ACC: begin
        used_nxt = used_r + XW'(pc_used);
        mw_nxt   = mw_r + XW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_we) dirty_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      limit_r      <= LIMIT_RST;
      dirty_r      <= 1'b0;
      used_r       <= '0;
      hint_r       <= '0;
      mw_r         <= '0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      dirty_r      <= dirty_nxt;
      used_r       <= used_nxt;
      hint_r       <= hint_nxt;
      mw_r         <= mw_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    ms_r        <= ms_nxt;
    ew_r        <= ew_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    hb_r        <= hb_nxt;
    set_r       <= set_nxt;
    scan_word_r <= scan_word_nxt;
    sw_r        <= sw_nxt;
    proc_word_r <= proc_word_nxt;
    seen_r      <= seen_nxt;
    run_r       <= run_nxt;
    ffr_r       <= ffr_nxt;
    need_r      <= need_nxt;
    status_r    <= status_nxt;
    result_r    <= result_nxt;
    if (state_r == S_DONE) begin
      out_status_r       <= status_r;
      out_result_frame_r <= (status_r == STAT_OK) ? result_r : '0;
      out_free_count_r   <= COUNT_W'(lim - used_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_frame = out_result_frame_r;
  assign out_free_count   = out_free_count_r;

  a_used_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !dirty_r) |-> (used_r <= lim))
    else $error("used frame count above limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting a request");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_WR) |-> (mw_r <= ew_r))
    else $error("marking pass beyond its last word");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_valid && state_r == S_IDLE))
    else $error("result not issued after completion");

endmodule

// ===== dv/tb_bitmap_frame_allocator_core.sv =====
// Self-checking testbench for bitmap_frame_allocator_core: directed table plus random requests.
module tb_bitmap_frame_allocator_core;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 20000000;

  typedef struct {
    func_t            fn;
    logic [15:0]      idx;
    logic [16:0]      cnt;
    bit               typed;
    status_t          st;
    logic [15:0]      fr;
  } req_row_t;

  typedef struct {
    status_t          st;
    logic [15:0]      fr;
    logic [16:0]      fc;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [FRAME_W-1:0] in_frame_index = '0;
  logic [COUNT_W-1:0] in_count = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [FRAME_W-1:0] out_result_frame;
  logic [COUNT_W-1:0] out_free_count;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  bitmap_frame_allocator_core dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_frame_index, .in_count,
    .out_valid, .out_status, .out_result_frame, .out_free_count, .cfg_we, .cfg_wdata
  );

  always #10 clk = ~clk;

  bit          used_map [0:65535];
  int          scan_hint;
  int          used_cnt;
  int          frame_limit;
  alloc_resp_t pending_resp [$];
  int          errors;
  int          cycles;
  int          n_sent;
  int          n_seen;
  int          n_nomem;
  int          n_badarg;
  req_row_t    dir_tab [$];

  function automatic void set_frame(input int f, input bit u);
    if (used_map[f] != u) begin
      used_map[f] = u;
      used_cnt += u ? 1 : -1;
    end
  endfunction

  function automatic void set_limit(input logic [16:0] v);
    frame_limit = (v > 17'd65536) ? 65536 : int'(v);
    used_cnt = 0;
    for (int f = 0; f < frame_limit; f++) used_cnt += used_map[f];
  endfunction

  function automatic alloc_resp_t allocate_or_mark(input func_t fn, input logic [15:0] idx,
                                                   input logic [16:0] cnt);
    alloc_resp_t r;
    int need, run, ff, f;
    bit seen, found;
    r.st = STAT_OK;
    r.fr = '0;
    if (fn == FN_ALLOC_ONE || fn == FN_ALLOC_RUN) begin
      need = (fn == FN_ALLOC_ONE) ? 1 : int'(cnt);
      if (need == 0) r.st = STAT_BADARG;
      else if (need > frame_limit) r.st = STAT_NOMEM;
      else begin
        run = 0; ff = 0; seen = 0; found = 0;
        for (f = scan_hint; f < frame_limit; f++) begin
          if (used_map[f]) begin
            run = 0;
            continue;
          end
          if (!seen) begin
            seen = 1;
            ff = f;
          end
          run++;
          if (run == need) begin
            found = 1;
            break;
          end
        end
        if (!found) r.st = STAT_NOMEM;
        else begin
          for (int k = f + 1 - need; k <= f; k++) set_frame(k, 1'b1);
          scan_hint = ff;
          r.fr = 16'(f + 1 - need);
        end
      end
    end else begin
      if (cnt == 0 || int'(idx) + int'(cnt) > frame_limit) r.st = STAT_BADARG;
      else begin
        for (int k = 0; k < int'(cnt); k++) set_frame(int'(idx) + k, fn == FN_RESERVE);
        if (fn == FN_FREE && int'(idx) < scan_hint) scan_hint = int'(idx);
      end
    end
    r.fc = 17'(frame_limit - used_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_bitmap_frame_allocator_core failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    alloc_resp_t e;
    if (rst_n && out_valid) begin
      n_seen++;
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d frame=%0d free=%0d", $time,
                 out_status, out_result_frame, out_free_count);
        errors++;
      end else begin
        e = pending_resp.pop_front();
        if (out_status !== e.st || out_result_frame !== e.fr || out_free_count !== e.fc) begin
          $display("%0t: mismatch exp status=%0d frame=%0d free=%0d act status=%0d frame=%0d free=%0d",
                   $time, e.st, e.fr, e.fc, out_status, out_result_frame, out_free_count);
          errors++;
        end
      end
    end
  end

  // drive one transaction; start stays high afterwards
  task automatic send_req(input func_t fn, input logic [15:0] idx, input logic [16:0] cnt,
                          input bit typed, input status_t tst, input logic [15:0] tfr);
    alloc_resp_t r;
    start <= 1'b1;
    in_func <= fn;
    in_frame_index <= idx;
    in_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = allocate_or_mark(fn, idx, cnt);
    if (typed && (r.st != tst || r.fr != tfr)) begin
      $display("%0t: table mismatch exp status=%0d frame=%0d act status=%0d frame=%0d",
               $time, tst, tfr, r.st, r.fr);
      errors++;
    end
    if (r.st == STAT_NOMEM) n_nomem++;
    if (r.st == STAT_BADARG) n_badarg++;
    pending_resp.push_back(r);
    n_sent++;
  endtask

  task automatic idle_gap(input bit allow);
    int n;
    if (allow && $urandom_range(99) < 28) begin
      n = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [16:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    set_limit(v);
  endtask

  task automatic random_req(input bit allow_idle);
    int p, lim;
    func_t fn;
    logic [15:0] idx;
    logic [16:0] cnt;
    lim = (frame_limit == 0) ? 1 : frame_limit;
    p = $urandom_range(99);
    fn = (p < 35) ? FN_ALLOC_ONE : (p < 60) ? FN_ALLOC_RUN : (p < 85) ? FN_FREE : FN_RESERVE;
    p = $urandom_range(99);
    if (p < 80) cnt = 17'($urandom_range(1, (lim < 8) ? lim : 8));
    else if (p < 90) cnt = 17'($urandom_range(1, lim));
    else if (p < 95) cnt = '0;
    else cnt = 17'($urandom);
    p = $urandom_range(99);
    if (p < 85) idx = 16'($urandom_range(0, lim - 1));
    else idx = 16'($urandom);
    idle_gap(allow_idle);
    send_req(fn, idx, cnt, 1'b0, STAT_OK, '0);
  endtask

  initial begin
    logic [16:0] phase_lim [8] = '{17'd131071, 17'd0, 17'd1, 17'd64, 17'd200,
                                   17'd65536, 17'd1000, 17'd96};
    int per_phase [8] = '{60, 15, 20, 120, 140, 120, 120, 55};
    errors = 0; cycles = 0; n_sent = 0; n_seen = 0; n_nomem = 0; n_badarg = 0;
    scan_hint = 0;
    for (int f = 0; f < 65536; f++) used_map[f] = 1'b0;
    set_limit(LIMIT_RST);

    dir_tab.push_back('{FN_ALLOC_ONE, 16'd0,     17'd0,     1, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'd0,     17'd0,     1, STAT_BADARG, 16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'hffff,  17'd65537, 1, STAT_NOMEM,  16'd0});
    dir_tab.push_back('{FN_FREE,      16'hffff,  17'd2,     1, STAT_BADARG, 16'd0});
    dir_tab.push_back('{FN_RESERVE,   16'd5,     17'd0,     1, STAT_BADARG, 16'd0});
    dir_tab.push_back('{FN_FREE,      16'd0,     17'd0,     1, STAT_BADARG, 16'd0});
    dir_tab.push_back('{FN_RESERVE,   16'd10,    17'd100,   0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_RESERVE,   16'd20,    17'd5,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'd0,     17'd12,    0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_ONE, 16'd0,     17'd1,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'd3,     17'd4,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'd3,     17'd4,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'd0,     17'd3,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'hffff,  17'd1,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_ONE, 16'd0,     17'd0,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_RESERVE,   16'd0,     17'd65536, 0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_ONE, 16'd0,     17'd0,     0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'h8000,  17'd32768, 0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'd0,     17'd32768, 0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'd0,     17'd65536, 0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_ALLOC_RUN, 16'd0,     17'd65536, 0, STAT_OK,     16'd0});
    dir_tab.push_back('{FN_FREE,      16'h5555,  17'h0aaaa, 0, STAT_OK,     16'd0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (dir_tab[i]) begin
      idle_gap(1'b1);
      send_req(dir_tab[i].fn, dir_tab[i].idx, dir_tab[i].cnt, dir_tab[i].typed,
               dir_tab[i].st, dir_tab[i].fr);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_limit(phase_lim[ph]);
      for (int i = 0; i < per_phase[ph]; i++) random_req(!(ph == 4 || ph == 5));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d requests over 9 frame limits; %0d out-of-memory, %0d bad-argument",
             n_sent, n_nomem, n_badarg);
    $display("%0d responses checked, %0d errors", n_seen, errors);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("tb_bitmap_frame_allocator_core passed");
    end else begin
      $display("tb_bitmap_frame_allocator_core failed");
    end
    $finish;
  end

endmodule
